// ----- hw/rtl/greedy_box_nms_core_defines.svh -----
// Assertion macros for the greedy box NMS core.
`ifndef GREEDY_BOX_NMS_CORE_DEFINES_SVH
`define GREEDY_BOX_NMS_CORE_DEFINES_SVH

// Check a property on every rising clk edge outside of reset.
`define GBN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising clk edge, reset included.
`define GBN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/gbn_pkg.sv -----
// Types and constants shared by the greedy box NMS core.
`timescale 1ns / 1ps

package gbn_pkg;

  // Default depth of the kept list
  localparam int MAX_KEPT_DEF = 256;

  // Threshold register: 0.45 in units of 1/256, rounded down
  localparam int          THR_W     = 9;
  localparam logic [8:0]  THR_RESET = 9'd115;

  // Field and arithmetic widths
  localparam int COORD_W = 16;
  localparam int SIZE_W  = 15;
  localparam int EXT_W   = 18;            // edge plus size, signed
  localparam int AREA_W  = 2 * SIZE_W;    // width * height
  localparam int UNI_W   = AREA_W + 1;    // area + area - intersection
  localparam int PROD_W  = THR_W + UNI_W; // threshold * union
  localparam int BOX_W   = 2 * COORD_W + 2 * SIZE_W;
  localparam int ENTRY_W = BOX_W + AREA_W;
  localparam int SLOT_W  = 8;

  // Input word: one box
  typedef struct packed {
    logic                       first_of_set;
    logic signed [COORD_W-1:0]  box_left;
    logic signed [COORD_W-1:0]  box_top;
    logic        [SIZE_W-1:0]   box_width;
    logic        [SIZE_W-1:0]   box_height;
  } gbn_in_t;

  // Result word: one verdict per box
  typedef struct packed {
    logic              kept;
    logic [SLOT_W-1:0] kept_slot;
    logic              list_overflow;
  } gbn_out_t;

endpackage

// ----- hw/rtl/greedy_box_nms_core.sv -----
// Greedy non-maximum suppression core with a stored kept-box list.
`timescale 1ns / 1ps
`include "greedy_box_nms_core_defines.svh"

// Boxes arrive sorted by descending score, one word each. A box is compared
// with every box in the kept list through one pipelined overlap unit that
// takes one kept entry per cycle from the list memory; it is dropped when
// inter*256 > iou_threshold*union for any entry, otherwise it is appended
// and reported with its slot (or flagged list_overflow when the list holds
// MAX_KEPT boxes). The scan reads the kept entries in turn (none when
// first_of_set is set), a drain state waits until the overlap pipeline is
// empty, and the result is registered as the core leaves the done state,
// when the input becomes ready again. The single read port of the list
// memory and the five-stage overlap pipeline set the length of this work.
// One box is in work at a time; the next box is taken while a finished
// result still waits on out_stall. Write iou_threshold only while idle.
module greedy_box_nms_core #(
  parameter int MAX_KEPT = gbn_pkg::MAX_KEPT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  gbn_pkg::gbn_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output gbn_pkg::gbn_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [gbn_pkg::THR_W-1:0]     cfg_wdata
);

  import gbn_pkg::*;

  localparam int CNT_W = $clog2(MAX_KEPT + 1);
  localparam int IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int PIPE_N = 5;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [THR_W-1:0]  thr_r;
  logic              suppress_r;
  logic [PIPE_N-1:0] pv_r;

  gbn_in_t           box_r;
  logic [AREA_W-1:0] area_r;

  logic [ENTRY_W-1:0] kept_mem_r [MAX_KEPT];
  logic [ENTRY_W-1:0] rd_data_r;
  logic               rd_en;
  logic               wr_en;

  logic               in_fire;
  logic               out_free;
  logic               room;
  logic [CNT_W+SLOT_W-1:0] slot_ext;

  gbn_out_t          out_r;
  logic              out_valid_r;

  // Overlap unit signals
  logic signed [EXT_W-1:0] ax0, ax1, bx0, bx1, ay0, ay1, by0, by1;
  logic signed [EXT_W-1:0] lox, hix, loy, hiy, dx, dy;
  logic [SIZE_W-1:0]       iw_r, ih_r;
  logic [AREA_W-1:0]       karea1_r, karea2_r;
  logic [AREA_W-1:0]       inter_r, inter2_r;
  logic [UNI_W-1:0]        uni_r;
  logic [PROD_W-1:0]       prod_r, lhs_r;

  assign in_fire   = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign room      = (count_r < CNT_W'(MAX_KEPT));
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign slot_ext  = {{SLOT_W{1'b0}}, count_r};

  assign rd_en = (state_r == ST_SCAN) && (idx_r < count_r);
  assign wr_en = (state_r == ST_DONE) && out_free && !suppress_r && room;

  // Sequencer: issue one kept entry per cycle, drain, then report
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_SCAN;
          idx_nxt   = '0;
          if (in_data.first_of_set) begin
            count_nxt = '0;
          end
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          idx_nxt = idx_r + CNT_W'(1);
        end else begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pv_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
          if (wr_en) begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      thr_r       <= THR_RESET;
      pv_r        <= '0;
      out_valid_r <= 1'b0;
      suppress_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      pv_r    <= {pv_r[PIPE_N-2:0], rd_en};
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      // Clear on a new box, set by any kept entry that overlaps too much
      if (in_fire) begin
        suppress_r <= 1'b0;
      end else if (pv_r[PIPE_N-1] && (lhs_r > prod_r)) begin
        suppress_r <= 1'b1;
      end
      // Hold the result until taken, load a new one when done
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Latch the box and its area on acceptance
  always_ff @(posedge clk) begin
    if (in_fire) begin
      box_r  <= in_data;
      area_r <= AREA_W'(in_data.box_width) * AREA_W'(in_data.box_height);
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_r.kept          <= !suppress_r;
      out_r.kept_slot     <= wr_en ? slot_ext[SLOT_W-1:0] : '0;
      out_r.list_overflow <= !suppress_r && !room;
    end
  end

  // Kept-list memory: one read and one write port, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      kept_mem_r[count_r[IDX_W-1:0]] <= {area_r, box_r.box_height, box_r.box_width,
                                         box_r.box_top, box_r.box_left};
    end
    if (rd_en) begin
      rd_data_r <= kept_mem_r[idx_r[IDX_W-1:0]];
    end
  end

  // Stage 1: edge extents and overlap on each axis
  always_comb begin
    ax0 = {{2{box_r.box_left[COORD_W-1]}}, box_r.box_left};
    ay0 = {{2{box_r.box_top[COORD_W-1]}}, box_r.box_top};
    ax1 = ax0 + $signed({3'b000, box_r.box_width});
    ay1 = ay0 + $signed({3'b000, box_r.box_height});
    bx0 = {{2{rd_data_r[COORD_W-1]}}, rd_data_r[COORD_W-1:0]};
    by0 = {{2{rd_data_r[2*COORD_W-1]}}, rd_data_r[2*COORD_W-1:COORD_W]};
    bx1 = bx0 + $signed({3'b000, rd_data_r[2*COORD_W+SIZE_W-1:2*COORD_W]});
    by1 = by0 + $signed({3'b000, rd_data_r[BOX_W-1:2*COORD_W+SIZE_W]});
    lox = (ax0 > bx0) ? ax0 : bx0;
    hix = (ax1 < bx1) ? ax1 : bx1;
    loy = (ay0 > by0) ? ay0 : by0;
    hiy = (ay1 < by1) ? ay1 : by1;
    dx  = hix - lox;
    dy  = hiy - loy;
  end

  // Stages 2 to 5: intersection, union, threshold product
  always_ff @(posedge clk) begin
    iw_r     <= (hix > lox) ? dx[SIZE_W-1:0] : '0;
    ih_r     <= (hiy > loy) ? dy[SIZE_W-1:0] : '0;
    karea1_r <= rd_data_r[ENTRY_W-1:BOX_W];
    inter_r  <= AREA_W'(iw_r) * AREA_W'(ih_r);
    karea2_r <= karea1_r;
    uni_r    <= UNI_W'(area_r) + UNI_W'(karea2_r) - UNI_W'(inter_r);
    inter2_r <= inter_r;
    prod_r   <= PROD_W'(thr_r) * PROD_W'(uni_r);
    lhs_r    <= {{(PROD_W-AREA_W-8){1'b0}}, inter2_r, 8'h00};
  end

  // Checks
  `GBN_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == ST_IDLE && !out_valid_r), "not idle after reset")
  `GBN_ASSERT(a_accept_starts_scan, in_fire |=> (state_r == ST_SCAN), "accepted box did not start a scan")
  `GBN_ASSERT(a_count_bound, count_r <= CNT_W'(MAX_KEPT), "kept count beyond list depth")
  `GBN_ASSERT(a_done_holds, (state_r == ST_DONE && out_valid_r && out_stall) |=> (state_r == ST_DONE), "result lost")
  `GBN_ASSERT(a_overflow_form, out_valid_r |-> (!out_r.list_overflow || (out_r.kept && out_r.kept_slot == '0)), "bad overflow word")

endmodule

// ----- verif/tb_greedy_box_nms_core.sv -----
// Self-checking testbench for the greedy box NMS core: boxes in, keep verdicts out.
`timescale 1ns / 1ps

module tb_greedy_box_nms_core;
  import gbn_pkg::*;

  localparam int LIST_DEPTH    = MAX_KEPT_DEF;
  localparam int SETTLE_CYCLES = LIST_DEPTH + 40;
  localparam int QUIET_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASES        = 6;
  localparam int PHASE_BOXES   = 70;
  localparam int FLOOD_BOXES   = LIST_DEPTH + 6;

  // Kept-list predictor and queue of pending verdicts
  class nms_scoreboard;
    gbn_in_t          kept_box [LIST_DEPTH];
    longint           kept_area[LIST_DEPTH];
    int               kept_cnt;
    logic [THR_W-1:0] thr;
    gbn_out_t         verdict_q[$];
    int               errors;

    function new();
      kept_cnt = 0;
      thr      = THR_RESET;
      errors   = 0;
    endfunction

    function longint span_overlap(longint a0, longint a1, longint b0, longint b1);
      longint lo, hi;
      lo = (a0 > b0) ? a0 : b0;
      hi = (a1 < b1) ? a1 : b1;
      return (hi > lo) ? hi - lo : 0;
    endfunction

    // Run one accepted box against the kept list and queue its verdict
    function void note_box(gbn_in_t b);
      longint   l, t, w, h, area, kl, kt, kw, kh, iw, ih, inter, uni;
      bit       keep;
      gbn_out_t v;
      int       k;
      l    = $signed(b.box_left);
      t    = $signed(b.box_top);
      w    = b.box_width;
      h    = b.box_height;
      area = w * h;
      keep = 1'b1;
      if (b.first_of_set) kept_cnt = 0;
      for (k = 0; k < kept_cnt; k++) begin
        kl    = $signed(kept_box[k].box_left);
        kt    = $signed(kept_box[k].box_top);
        kw    = kept_box[k].box_width;
        kh    = kept_box[k].box_height;
        iw    = span_overlap(l, l + w, kl, kl + kw);
        ih    = span_overlap(t, t + h, kt, kt + kh);
        inter = iw * ih;
        uni   = area + kept_area[k] - inter;
        // drop on IoU strictly above threshold/256
        if (inter * 256 > longint'(thr) * uni) keep = 1'b0;
      end
      v.kept          = keep;
      v.kept_slot     = '0;
      v.list_overflow = 1'b0;
      if (keep) begin
        if (kept_cnt < LIST_DEPTH) begin
          kept_box[kept_cnt]  = b;
          kept_area[kept_cnt] = area;
          v.kept_slot         = SLOT_W'(kept_cnt);
          kept_cnt++;
        end else begin
          v.list_overflow = 1'b1;
        end
      end
      verdict_q.insert(verdict_q.size(), v);
    endfunction

    // Compare one result word with the oldest pending verdict
    function void check_verdict(gbn_out_t got);
      gbn_out_t want;
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected verdict kept=%0b slot=%0d overflow=%0b",
                 $time, got.kept, got.kept_slot, got.list_overflow);
        errors++;
        return;
      end
      want = verdict_q.pop_front();
      if (got.kept !== want.kept) begin
        $display("%0t: kept expected %0b actual %0b", $time, want.kept, got.kept);
        errors++;
      end
      if (got.kept_slot !== want.kept_slot) begin
        $display("%0t: kept_slot expected %0d actual %0d", $time, want.kept_slot,
                 got.kept_slot);
        errors++;
      end
      if (got.list_overflow !== want.list_overflow) begin
        $display("%0t: list_overflow expected %0b actual %0b", $time,
                 want.list_overflow, got.list_overflow);
        errors++;
      end
    endfunction
  endclass

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  gbn_in_t          in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  gbn_out_t         out_data;
  logic             cfg_we    = 1'b0;
  logic [THR_W-1:0] cfg_wdata = THR_RESET;

  nms_scoreboard nms;
  bit            idling   = 1'b0;
  bit            hold_req = 1'b0;

  greedy_box_nms_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic gbn_in_t mk_box(bit first, int l, int t, int w, int h);
    gbn_in_t b;
    b.first_of_set = first;
    b.box_left     = l[COORD_W-1:0];
    b.box_top      = t[COORD_W-1:0];
    b.box_width    = w[SIZE_W-1:0];
    b.box_height   = h[SIZE_W-1:0];
    return b;
  endfunction

  // Offer one box, hold it until taken, then maybe idle for a burst
  task automatic send_box(input gbn_in_t b);
    in_data  <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    nms.note_box(b);
    if (idling && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every pending verdict has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (nms.verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] v);
    drain_results();
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    nms.thr = v;
  endtask

  // Result side: check accepted words, stall in random bursts and one long hold
  initial begin : result_sink
    int stall_left;
    bit hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) nms.check_verdict(out_data);
      if (hold_req && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idling && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 17);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // End the run when no word moves on either channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("greedy_box_nms_core test failed");
    $finish;
  end

  initial begin : stimulus
    gbn_in_t          anchor, b;
    bit               first;
    int               l, t, w, h, jx, jy;
    logic [THR_W-1:0] thr_plan [PHASES];
    int               p, i;

    nms = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed boxes at the reset threshold
    idling = 1'b1;
    send_box(mk_box(1, -32768, -32768, 32767, 32767));
    send_box(mk_box(0, -32768, -32768, 32767, 32767));   // identical: drop
    send_box(mk_box(0, 32767, 32767, 32767, 32767));     // disjoint, edges past 16 bits
    send_box(mk_box(0, -1, -32768, 100, 100));           // touches the first box
    send_box(mk_box(0, 0, 0, 0, 0));                     // zero area
    send_box(mk_box(0, 0, 0, 0, 0));                     // zero union with previous
    send_box(mk_box(1, 0, 0, 160, 160));                 // new set clears the list
    send_box(mk_box(0, 16, 0, 160, 160));                // heavy overlap: drop
    send_box(mk_box(0, 80, 0, 160, 160));                // light overlap: keep
    send_box(mk_box(0, 1000, 1000, 256, 1));
    send_box(mk_box(0, 1050, 1000, 115, 1));             // IoU exactly at threshold
    send_box(mk_box(0, 1050, 1000, 116, 1));             // just above threshold
    send_box(mk_box(0, -80, -80, 160, 160));             // straddles zero
    send_box(mk_box(0, 32000, 32000, 32767, 32767));     // near full area
    send_box(mk_box(0, 32100, 32100, 32767, 32767));
    send_box(mk_box(0, 32767, -32768, 0, 32767));
    send_box(mk_box(0, -32768, 32767, 32767, 0));

    // Nothing suppressed at 256: fill the list and run past it
    write_threshold(9'd256);
    for (i = 0; i < FLOOD_BOXES; i++) begin
      send_box(mk_box(i == 0, $urandom, $urandom, $urandom_range(0, 200),
                      $urandom_range(0, 200)));
    end

    thr_plan[0] = 9'd0;
    thr_plan[1] = 9'd255;
    thr_plan[2] = 9'd1;
    thr_plan[3] = THR_W'($urandom_range(0, 256));
    thr_plan[4] = 9'd115;
    thr_plan[5] = THR_W'($urandom_range(0, 256));
    anchor = '0;

    // Random sets of clustered boxes with some noise mixed in
    for (p = 0; p < PHASES; p++) begin
      write_threshold(thr_plan[p]);
      if (p == 1) hold_req <= 1'b1;
      for (i = 0; i < PHASE_BOXES; i++) begin
        idling = (p != PHASES - 1) && ((i / 25) % 3 != 2);
        if (p == 2 && i == PHASE_BOXES / 2) drain_results();
        first = (i == 0) || ($urandom_range(0, 11) == 0);
        if (first || $urandom_range(0, 5) == 0) begin
          w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767) : $urandom_range(16, 4000);
          h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767) : $urandom_range(16, 4000);
          anchor = mk_box(1, $urandom, $urandom, w, h);
        end
        if ($urandom_range(0, 6) == 0) begin
          b = mk_box(first, $urandom, $urandom, $urandom, $urandom);
        end else begin
          // jitter position and size around the set's anchor
          jx = int'(anchor.box_width) / 2 + 1;
          jy = int'(anchor.box_height) / 2 + 1;
          l  = int'($signed(anchor.box_left)) + int'($urandom_range(0, 2 * jx)) - jx;
          t  = int'($signed(anchor.box_top)) + int'($urandom_range(0, 2 * jy)) - jy;
          w  = int'(anchor.box_width) * int'($urandom_range(75, 125)) / 100;
          h  = int'(anchor.box_height) * int'($urandom_range(75, 125)) / 100;
          if (w > 32767) w = 32767;
          if (h > 32767) h = 32767;
          b = mk_box(first, l, t, w, h);
        end
        send_box(b);
      end
    end

    // Wait out the last verdicts and catch any stray words
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (nms.errors == 0 && nms.verdict_q.size() == 0) begin
      $display("greedy_box_nms_core test passed");
    end else begin
      $display("greedy_box_nms_core test failed");
    end
    $finish;
  end

endmodule
